// ===== rtl/dtq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg: shared definitions of the deadline timer queue
// Widths, depth, command and result codes, and the control and status
// groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DL_W   = 32;
    localparam int TMO_W  = 31;
    localparam int ID_W   = 8;
    localparam int MODE_W = 2;
    localparam int KIND_W = 2;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REPORT  = 2'd3;

    typedef struct packed {
        logic              load;
        logic              insert;
        logic              remove_step;
        logic              advance;
        logic              pop;
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic              last;
    } dtq_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              any_match;
        logic              head_expired;
        logic              out_free;
    } dtq_status_t;

endpackage

// ===== rtl/dtq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_ctrl: command sequencer of the deadline timer queue
// Takes one item at a time, steps the cell chain and issues each result
// to the output register when it is free.
// ----------------------------------------------------------------------------
module dtq_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dtq_pkg::dtq_status_t status,
    output dtq_pkg::dtq_cmd_t    cmd
);
    import dtq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_TICK = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = KIND_DONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (status.mode)
                    MODE_ADD:
                    begin
                        if (status.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            cmd.kind   = status.full ? KIND_FULL : KIND_DONE;
                            cmd.insert = !status.full;
                            state_next = S_IDLE;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (status.any_match)
                        begin
                            cmd.remove_step = 1'b1;
                        end
                        else if (status.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    MODE_TICK:
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_TICK;
                    end
                    default:
                    begin
                        if (status.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_TICK:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.head_expired)
                    begin
                        cmd.kind = KIND_EXPIRED;
                        cmd.pop  = 1'b1;
                    end
                    else
                    begin
                        cmd.kind   = KIND_REPORT;
                        cmd.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/dtq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_datapath: sorted cell chain, millisecond counter and output register
// Each cell holds a deadline and an owner; the chain shifts right to
// insert and left to pop or remove, one step per command.
// ----------------------------------------------------------------------------
module dtq_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dtq_pkg::dtq_cmd_t             cmd,
    output dtq_pkg::dtq_status_t          status,
    input  logic [dtq_pkg::MODE_W-1:0]    mode,
    input  logic [dtq_pkg::TMO_W-1:0]     timeout_ms,
    input  logic [dtq_pkg::ID_W-1:0]      watch_id,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dtq_pkg::KIND_W-1:0]    kind,
    output logic [dtq_pkg::ID_W-1:0]      expired_id,
    output logic [dtq_pkg::TMO_W-1:0]     remaining_ms,
    output logic                          none_pending,
    output logic                          last
);
    import dtq_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [TMO_W-1:0]  tmo_reg;
    logic [ID_W-1:0]   id_reg;

    logic [DL_W-1:0]   now_reg;
    logic [DL_W-1:0]   now_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic [DL_W-1:0]   deadline_reg  [DEPTH];
    logic [DL_W-1:0]   deadline_next [DEPTH];
    logic [ID_W-1:0]   owner_reg     [DEPTH];
    logic [ID_W-1:0]   owner_next    [DEPTH];

    logic [DL_W-1:0]   diff [DEPTH];
    logic [DEPTH-1:0]  vld;
    logic [DEPTH-1:0]  le;
    logic [DEPTH-1:0]  match;
    logic [DEPTH-1:0]  hit;
    logic [DL_W-1:0]   new_deadline;
    logic [DL_W-1:0]   new_key;
    logic              empty;

    logic              out_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [ID_W-1:0]   expired_id_reg;
    logic [TMO_W-1:0]  remaining_reg;
    logic              none_pending_reg;
    logic              last_reg;

    assign new_deadline = now_reg + {1'b0, tmo_reg};
    assign new_key      = {1'b1, tmo_reg};
    assign empty        = (count_reg == '0);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            diff[i]  = deadline_reg[i] - now_reg;
            vld[i]   = (CNT_W'(i) < count_reg);
            le[i]    = vld[i] && ({~diff[i][DL_W-1], diff[i][DL_W-2:0]} <= new_key);
            match[i] = vld[i] && (owner_reg[i] == id_reg);
        end
        hit[0] = match[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            hit[i] = hit[i-1] | match[i];
        end
    end

    always_comb
    begin
        status.mode         = mode_reg;
        status.full         = (count_reg == CNT_W'(DEPTH));
        status.any_match    = hit[DEPTH-1];
        status.head_expired = !empty && ((diff[0] == '0) || diff[0][DL_W-1]);
        status.out_free     = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        now_next   = now_reg;
        count_next = count_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            deadline_next[i] = deadline_reg[i];
            owner_next[i]    = owner_reg[i];
        end
        if (cmd.advance)
        begin
            now_next = now_reg + DL_W'(1);
        end
        if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
            if (!le[0])
            begin
                deadline_next[0] = new_deadline;
                owner_next[0]    = id_reg;
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (!le[i])
                begin
                    if (le[i-1])
                    begin
                        deadline_next[i] = new_deadline;
                        owner_next[i]    = id_reg;
                    end
                    else
                    begin
                        deadline_next[i] = deadline_reg[i-1];
                        owner_next[i]    = owner_reg[i-1];
                    end
                end
            end
        end
        if (cmd.remove_step || cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                if (cmd.pop || hit[i])
                begin
                    deadline_next[i] = deadline_reg[i+1];
                    owner_next[i]    = owner_reg[i+1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            now_reg   <= now_next;
            count_reg <= count_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            deadline_reg[i] <= deadline_next[i];
            owner_reg[i]    <= owner_next[i];
        end
        if (cmd.load)
        begin
            mode_reg <= mode;
            tmo_reg  <= timeout_ms;
            id_reg   <= watch_id;
        end
        if (cmd.emit)
        begin
            kind_reg         <= cmd.kind;
            last_reg         <= cmd.last;
            expired_id_reg   <= (cmd.kind == KIND_EXPIRED) ? owner_reg[0] : '0;
            remaining_reg    <= (cmd.kind == KIND_REPORT && !empty) ?
                                diff[0][TMO_W-1:0] : '0;
            none_pending_reg <= (cmd.kind == KIND_REPORT) && empty;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign expired_id   = expired_id_reg;
    assign remaining_ms = remaining_reg;
    assign none_pending = none_pending_reg;
    assign last         = last_reg;

endmodule

// ===== rtl/deadline_timer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_queue: deadline-sorted queue of millisecond timers
// Adds, removes and expires timers held in a sorted cell chain.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------
//   in      | in_valid, in_stall  | mode, timeout_ms, watch_id
//   out     | out_valid, out_stall| kind, expired_id, remaining_ms,
//           |                     | none_pending, last
//
// An add is done in a single step; a remove takes one compaction step of the
// cell chain per matching timer; a tick advances the counter and then gives one
// result per expired timer (one pop each) and a report; output stalls delay them.
// One item is worked on at a time; the next transfer is taken once the
// last result of the previous item is in the output register.
// Reset clears the counter, the fill count and the output valid; cells
// above the fill count are never read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module deadline_timer_queue
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [dtq_pkg::MODE_W-1:0] mode,
    input  logic [dtq_pkg::TMO_W-1:0]  timeout_ms,
    input  logic [dtq_pkg::ID_W-1:0]   watch_id,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [dtq_pkg::KIND_W-1:0] kind,
    output logic [dtq_pkg::ID_W-1:0]   expired_id,
    output logic [dtq_pkg::TMO_W-1:0]  remaining_ms,
    output logic                       none_pending,
    output logic                       last
);
    import dtq_pkg::*;

    dtq_cmd_t    cmd;
    dtq_status_t status;

    dtq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    dtq_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .mode         (mode),
        .timeout_ms   (timeout_ms),
        .watch_id     (watch_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .expired_id   (expired_id),
        .remaining_ms (remaining_ms),
        .none_pending (none_pending),
        .last         (last)
    );

endmodule
